[hdl/tds_pkg.sv]
// shared types and constants for the timer deadline scheduler
// no dependencies
package tds_pkg;
  localparam int TIMER_COUNT = 16;
  localparam int TIME_BITS = 32;
  localparam int IDX_BITS = $clog2(TIMER_COUNT);
  localparam int SEQ_BITS = 64;

  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_STOP = 3'd1;
  localparam logic [2:0] KIND_AGAIN = 3'd2;
  localparam logic [2:0] KIND_SET_REPEAT = 3'd3;
  localparam logic [2:0] KIND_TICK = 3'd4;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NOT_STARTED = 2'd1;
  localparam logic [1:0] STATUS_BACKWARDS = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] timer_index;
    logic [31:0] timeout;
    logic [31:0] repeat_period;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic expired_valid;
    logic [3:0] expired_index;
    logic [31:0] repeat_value;
    logic last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic is_tick;
    logic is_noop;
    logic [2:0] kind;
    logic [IDX_BITS-1:0] idx;
    logic [TIME_BITS-1:0] tmo;
    logic [TIME_BITS-1:0] rep;
    logic [TIME_BITS-1:0] now;
  } cmd_t;
endpackage

[hdl/tds_front.sv]
// front end: accepts items, classifies them and queues commands
// depends on tds_pkg
module tds_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  tds_pkg::in_item_t item_in,
  output logic cmd_valid,
  output tds_pkg::cmd_t cmd,
  input  logic cmd_take
);
  import tds_pkg::*;

  cmd_t q [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  cmd_t c;
  logic do_push, do_pop;

  always_comb begin
    c.kind = item_in.kind;
    c.is_tick = (item_in.kind == KIND_TICK);
    c.is_noop = (item_in.kind > KIND_TICK) ||
                ({28'd0, item_in.timer_index} >= TIMER_COUNT);
    c.idx = item_in.timer_index[IDX_BITS-1:0];
    c.tmo = item_in.timeout[TIME_BITS-1:0];
    c.rep = item_in.repeat_period[TIME_BITS-1:0];
    c.now = item_in.now[TIME_BITS-1:0];
  end

  assign full = (count == 2'd2);
  assign do_push = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign do_pop = cmd_take && cmd_valid;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= c;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |=> count != 2'd0 || $past(do_pop))
    else $error("queue count jumped");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_valid_track: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> cmd_valid) else $error("pushed command lost");
`endif
endmodule

[hdl/tds_back.sv]
// back end: timer table, sequencer for commands and tick scans, result queue
// depends on tds_pkg
module tds_back (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  tds_pkg::cmd_t cmd,
  output logic cmd_take,
  output logic empty,
  input  logic pop,
  output tds_pkg::out_item_t item_out
);
  import tds_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIRE = 2'd2;

  logic [TIMER_COUNT-1:0] active, started, fired;
  logic [TIME_BITS-1:0] deadline [TIMER_COUNT];
  logic [TIME_BITS-1:0] rep_tab [TIMER_COUNT];
  logic [SEQ_BITS-1:0] seq_tab [TIMER_COUNT];
  logic [TIME_BITS-1:0] cur_time;
  logic [SEQ_BITS-1:0] next_seq;

  logic [1:0] state;
  logic [IDX_BITS-1:0] scan_i;
  logic best_ok;
  logic [IDX_BITS-1:0] best;
  logic any_fired;

  // output skid register
  logic ov;
  out_item_t oreg;
  logic emit;
  out_item_t emit_item;
  logic space;

  assign empty = !ov;
  assign item_out = oreg;
  assign space = !ov || pop;

  // saturating deadline
  function automatic logic [TIME_BITS-1:0] sat_add(
    input logic [TIME_BITS-1:0] a, input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  logic cand_better;
  always_comb begin
    cand_better = active[scan_i] && !fired[scan_i] &&
      (!best_ok || deadline[scan_i] < deadline[best] ||
       (deadline[scan_i] == deadline[best] && seq_tab[scan_i] < seq_tab[best]));
  end

  logic [TIME_BITS-1:0] cmd_rep_after;
  always_comb begin
    cmd_take = 1'b0;
    emit = 1'b0;
    emit_item = '0;
    cmd_rep_after = (cmd.kind == KIND_START || cmd.kind == KIND_SET_REPEAT) ?
                    cmd.rep : rep_tab[cmd.idx];
    case (state)
      ST_IDLE: begin
        if (cmd_valid && space) begin
          emit_item.last = 1'b1;
          if (cmd.is_tick) begin
            if (cmd.now < cur_time) begin
              emit = 1'b1;
              cmd_take = 1'b1;
              emit_item.status = STATUS_BACKWARDS;
            end
          end else begin
            emit = 1'b1;
            cmd_take = 1'b1;
            if (!cmd.is_noop) begin
              if (cmd.kind == KIND_AGAIN && !started[cmd.idx])
                emit_item.status = STATUS_NOT_STARTED;
              emit_item.repeat_value = 32'(cmd_rep_after);
            end
          end
        end
      end
      ST_FIRE: begin
        if (space) begin
          if (best_ok && deadline[best] <= cur_time) begin
            emit = 1'b1;
            emit_item.expired_valid = 1'b1;
            emit_item.expired_index = 4'(best);
            emit_item.repeat_value = 32'(rep_tab[best]);
          end else begin
            cmd_take = 1'b1;
            if (!any_fired) begin
              emit = 1'b1;
              emit_item.last = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // the last flag of a firing is known only after the next re-scan, so a fired
  // result is held in pend and the load logic below sets last on the final one
  logic pend_v;
  out_item_t pend;
  logic load;
  out_item_t load_item;

  // what the output register takes this cycle
  always_comb begin
    load = 1'b0;
    load_item = emit_item;
    if (emit && emit_item.expired_valid) begin
      load = pend_v;
      load_item = pend;
    end else if (pend_v && state == ST_FIRE && (emit || cmd_take)) begin
      load = 1'b1;
      load_item = pend;
      load_item.last = 1'b1;
    end else if (emit) begin
      load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active <= '0;
      started <= '0;
      fired <= '0;
      cur_time <= '0;
      next_seq <= '0;
      ov <= 1'b0;
      pend_v <= 1'b0;
      scan_i <= '0;
      best_ok <= 1'b0;
      any_fired <= 1'b0;
      for (int i = 0; i < TIMER_COUNT; i++) rep_tab[i] <= '0;
    end else begin
      // output: a held fired result is released once the next is known
      if (load) begin
        oreg <= load_item;
        ov <= 1'b1;
      end else if (pop && ov) begin
        ov <= 1'b0;
      end
      if (emit && emit_item.expired_valid) begin
        pend <= emit_item;
        pend_v <= 1'b1;
      end else if (pend_v && state == ST_FIRE && (emit || cmd_take)) begin
        pend_v <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cmd_valid && space) begin
            if (cmd.is_tick) begin
              if (!(cmd.now < cur_time)) begin
                cur_time <= cmd.now;
                fired <= '0;
                any_fired <= 1'b0;
                scan_i <= '0;
                best_ok <= 1'b0;
                state <= ST_SCAN;
              end
            end else if (!cmd.is_noop) begin
              case (cmd.kind)
                KIND_START: begin
                  rep_tab[cmd.idx] <= cmd.rep;
                  deadline[cmd.idx] <= sat_add(cur_time, cmd.tmo);
                  seq_tab[cmd.idx] <= next_seq;
                  next_seq <= next_seq + SEQ_BITS'(1);
                  active[cmd.idx] <= 1'b1;
                  started[cmd.idx] <= 1'b1;
                end
                KIND_STOP: active[cmd.idx] <= 1'b0;
                KIND_AGAIN: begin
                  if (started[cmd.idx] && rep_tab[cmd.idx] != '0) begin
                    deadline[cmd.idx] <= sat_add(cur_time, rep_tab[cmd.idx]);
                    seq_tab[cmd.idx] <= next_seq;
                    next_seq <= next_seq + SEQ_BITS'(1);
                    active[cmd.idx] <= 1'b1;
                  end
                end
                KIND_SET_REPEAT: rep_tab[cmd.idx] <= cmd.rep;
                default: ;
              endcase
            end
          end
        end
        ST_SCAN: begin
          if (cand_better) begin
            best <= scan_i;
            best_ok <= 1'b1;
          end
          scan_i <= scan_i + IDX_BITS'(1);
          if (scan_i == IDX_BITS'(TIMER_COUNT - 1)) state <= ST_FIRE;
        end
        ST_FIRE: begin
          if (space) begin
            if (best_ok && deadline[best] <= cur_time) begin
              fired[best] <= 1'b1;
              any_fired <= 1'b1;
              // a repeating timer stays armed at its new deadline
              active[best] <= (rep_tab[best] != '0);
              if (rep_tab[best] != '0) begin
                deadline[best] <= sat_add(cur_time, rep_tab[best]);
                seq_tab[best] <= next_seq;
                next_seq <= next_seq + SEQ_BITS'(1);
              end
              scan_i <= '0;
              best_ok <= 1'b0;
              state <= ST_SCAN;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fired_inactive: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIRE && $past(state) == ST_SCAN && best_ok |-> !fired[best])
    else $error("timer picked twice in one tick");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> state == ST_IDLE) else $error("take left sequencer busy");
  a_pend_fire: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_v) else $error("held result left behind");
`endif
endmodule

[hdl/timer_deadline_scheduler.sv]
// top level of the timer deadline scheduler
// depends on tds_pkg, tds_front, tds_back
//
// sixteen software timers kept in a flip-flop table. a command (start, stop,
// again, set repeat) is handled by the sequencer in its idle state, and its
// result item is loaded into the output register. a tick that goes backwards
// only returns a status; any other tick scans the table once per fired timer
// plus one final scan, each scan being 16 compare steps and one fire step.
// the sequential scan of the timer table sets how long a tick takes. a fired
// item is held back one scan until the next is known, so the last flag can be
// set. a two-entry command queue decouples the input from the sequencer, and
// an output register holds results; while it holds an item that is not
// popped, the sequencer waits.
module timer_deadline_scheduler (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  tds_pkg::in_item_t in_item,
  output logic empty,
  input  logic pop,
  output tds_pkg::out_item_t out_item
);
  import tds_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  // front: accept and classify
  tds_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item_in(in_item),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  // back: timer table and tick scan
  tds_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .empty(empty), .pop(pop), .item_out(out_item)
  );

`ifndef NO_ASSERTIONS
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_item.status != 2'd3) else $error("bad status");
  a_fire_status: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.expired_valid |-> out_item.status == STATUS_OK)
    else $error("fired result with error");
`endif
endmodule

[test/timer_deadline_scheduler_chk.sv]
// checker for the timer deadline scheduler: predicts results from accepted items
// and compares them with accepted results; depends on tds_pkg
module timer_deadline_scheduler_chk (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic full,
  input  tds_pkg::in_item_t in_item,
  input  logic empty,
  input  logic pop,
  input  tds_pkg::out_item_t out_item,
  output int errors,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tds_pkg::*;

  logic        armed_q [TIMER_COUNT];
  logic        started_q [TIMER_COUNT];
  logic [31:0] deadline_q [TIMER_COUNT];
  logic [31:0] period_q [TIMER_COUNT];
  logic [63:0] stamp_q [TIMER_COUNT];
  logic [31:0] clock_now;
  logic [63:0] stamp_next;
  out_item_t   due_q[$];

  assign pending = due_q.size();

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic arm_timer(int t, logic [31:0] delay);
    deadline_q[t] = sat_add(clock_now, delay);
    stamp_q[t] = stamp_next;
    stamp_next = stamp_next + 64'd1;
    armed_q[t] = 1'b1;
    started_q[t] = 1'b1;
  endtask

  task automatic add_result(logic [1:0] st, logic v, logic [3:0] idx, logic [31:0] rep,
                            logic lst);
    out_item_t r;
    r.status = st;
    r.expired_valid = v;
    r.expired_index = idx;
    r.repeat_value = rep;
    r.last = lst;
    due_q.push_back(r);
  endtask

  task automatic predict_item(in_item_t it);
    logic fired [TIMER_COUNT];
    int best;
    int n;
    int t;
    t = it.timer_index;
    if (it.kind == KIND_TICK) begin
      if (it.now < clock_now) begin
        add_result(STATUS_BACKWARDS, 1'b0, 4'd0, 32'd0, 1'b1);
        return;
      end
      clock_now = it.now;
      foreach (fired[i]) fired[i] = 1'b0;
      n = 0;
      for (int k = 0; k < TIMER_COUNT; k++) begin
        best = -1;
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (armed_q[i] && !fired[i]) begin
            if (best < 0 || deadline_q[i] < deadline_q[best] ||
                (deadline_q[i] == deadline_q[best] && stamp_q[i] < stamp_q[best]))
              best = i;
          end
        end
        if (best < 0 || deadline_q[best] > clock_now) break;
        fired[best] = 1'b1;
        armed_q[best] = 1'b0;
        if (period_q[best] != 0) arm_timer(best, period_q[best]);
        add_result(STATUS_OK, 1'b1, best[3:0], period_q[best], 1'b0);
        n++;
      end
      if (n == 0) add_result(STATUS_OK, 1'b0, 4'd0, 32'd0, 1'b1);
      else due_q[$].last = 1'b1;
      return;
    end
    case (it.kind)
      KIND_START: begin
        period_q[t] = it.repeat_period;
        arm_timer(t, it.timeout);
      end
      KIND_STOP: armed_q[t] = 1'b0;
      KIND_AGAIN: begin
        if (!started_q[t]) begin
          add_result(STATUS_NOT_STARTED, 1'b0, 4'd0, period_q[t], 1'b1);
          return;
        end
        if (period_q[t] != 0) arm_timer(t, period_q[t]);
      end
      KIND_SET_REPEAT: period_q[t] = it.repeat_period;
      default: begin
        add_result(STATUS_OK, 1'b0, 4'd0, 32'd0, 1'b1);
        return;
      end
    endcase
    add_result(STATUS_OK, 1'b0, 4'd0, period_q[t], 1'b1);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      foreach (armed_q[i]) begin
        armed_q[i] = 1'b0;
        started_q[i] = 1'b0;
        deadline_q[i] = '0;
        period_q[i] = '0;
        stamp_q[i] = '0;
      end
      clock_now = '0;
      stamp_next = '0;
      due_q.delete();
      errors = 0;
    end else begin
      if (pop && !empty) begin
        if (due_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_item);
        end else begin
          want = due_q.pop_front();
          if (want !== out_item) begin
            errors++;
            if (errors <= 10) $display("result differs: expected %p got %p", want, out_item);
          end
        end
      end
      if (push && !full) predict_item(in_item);
    end
  end
endmodule

[test/timer_deadline_scheduler_tb.sv]
// top of the timer deadline scheduler testbench: clock, reset, stimulus, verdict
// depends on tds_pkg, timer_deadline_scheduler, timer_deadline_scheduler_chk
module timer_deadline_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tds_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  in_item = '0;
  out_item_t out_item;
  int        errors;
  int        pending;
  int        cycles = 0;
  logic      hold_pop = 1'b0;   // long receiver hold-off in progress
  logic [31:0] tick_time = 32'd0;   // highest time carried by a tick sent so far

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timer_deadline_scheduler u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  timer_deadline_scheduler_chk u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .errors(errors), .pending(pending)
  );

  // watchdog: worst case is far below this
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("timer_deadline_scheduler: mismatch");
      $finish;
    end
  end

  // offer one item after an optional idle gap and hold it until accepted;
  // push stays high so the next item can follow with no gap
  task automatic send_item(in_item_t it);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 2) == 0) gap = 0;   // stretches with no idling
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [2:0] kind, logic [3:0] idx,
                                         logic [31:0] tmo, logic [31:0] rep,
                                         logic [31:0] at);
    in_item_t it;
    it.kind = kind;
    it.timer_index = idx;
    it.timeout = tmo;
    it.repeat_period = rep;
    it.now = at;
    return it;
  endfunction

  // random 32-bit value biased to small numbers and edges
  function automatic logic [31:0] rand_span();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  // tick that mostly moves forward, sometimes stays, goes backward, jumps to a random time or to the very end of time
  task automatic send_tick();
    logic [31:0] at;
    case ($urandom_range(0, 9))
      0: at = (tick_time == 0) ? 32'd0 : tick_time - $urandom_range(1, 5);
      1: at = $urandom;
      2: at = 32'hFFFF_FFFF;
      3: at = tick_time;
      default: at = tick_time + $urandom_range(1, 40);
    endcase
    if (at >= tick_time) tick_time = at;
    send_item(make_item(KIND_TICK, 4'($urandom), $urandom, $urandom, at));
  endtask

  task automatic send_random();
    logic [2:0] kind;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) kind = KIND_START;
    else if (r < 40) kind = KIND_STOP;
    else if (r < 52) kind = KIND_AGAIN;
    else if (r < 60) kind = KIND_SET_REPEAT;
    else if (r < 95) kind = KIND_TICK;
    else kind = 3'($urandom_range(5, 7));
    if (kind == KIND_TICK) send_tick();
    else send_item(make_item(kind, 4'($urandom), rand_span(), rand_span(), $urandom));
  endtask

  // receiver: random per-item stalls, one long hold-off on request
  initial begin
    int wait_n;
    @(negedge rst);
    forever begin
      if (hold_pop) begin
        pop <= 1'b0;
        @(posedge clk);
      end else begin
        wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        if (wait_n > 0) begin
          pop <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
        pop <= 1'b1;
        @(posedge clk);
        while (empty && !hold_pop) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: never-started again, out-of-range kinds, field extremes
    send_item(make_item(KIND_AGAIN, 4'd15, '0, '0, '0));
    send_item(make_item(3'd5, 4'd0, '1, '1, '1));
    send_item(make_item(3'd7, 4'd15, '0, '0, '0));
    send_item(make_item(KIND_SET_REPEAT, 4'd3, '0, 32'd7, '0));
    send_item(make_item(KIND_AGAIN, 4'd3, '0, '0, '0));
    // two timers on one deadline, one of them stopped before the tick
    send_item(make_item(KIND_START, 4'd9, 32'd10, 32'd0, '0));
    send_item(make_item(KIND_START, 4'd2, 32'd10, 32'd5, '0));
    send_item(make_item(KIND_START, 4'd0, 32'd4, 32'd0, '0));
    send_item(make_item(KIND_START, 4'd15, '1, '1, '0));   // saturated deadline
    send_item(make_item(KIND_START, 4'd0, 32'd3, 32'd0, '0));   // re-arm active timer
    send_item(make_item(KIND_AGAIN, 4'd0, '0, '0, '0));   // zero repeat
    send_item(make_item(KIND_STOP, 4'd9, '0, '0, '0));
    send_item(make_item(KIND_TICK, 4'd0, '0, '0, 32'd20));
    send_item(make_item(KIND_TICK, 4'd0, '0, '0, 32'd19));   // backwards
    send_item(make_item(KIND_AGAIN, 4'd2, '0, '0, '0));
    // every timer repeating, then a tick to the end of time fires all once each
    for (int i = 0; i < TIMER_COUNT; i++)
      send_item(make_item(KIND_START, 4'(i), 32'd1, 32'hFFFF_FFFF - i, '0));
    send_item(make_item(KIND_TICK, 4'd0, '0, '0, 32'hFFFF_FFFF));
    send_item(make_item(KIND_TICK, 4'd0, '0, '0, 32'hFFFF_FFFF));

    // time is now at its maximum; reset is not repeated, so random ticks mostly
    // go backwards or land on the same time, and starts with timeout 0 still fire
    tick_time = 32'hFFFF_FFFF;

    // long receiver hold-off while items keep coming
    fork
      begin
        hold_pop = 1'b1;
        repeat (600) @(posedge clk);
        hold_pop = 1'b0;
      end
      repeat (40) send_random();
    join

    repeat (310) send_random();
    push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("timer_deadline_scheduler: match");
    end else begin
      $display("timer_deadline_scheduler: mismatch");
    end
    $finish;
  end
endmodule

[files.f]
hdl/tds_pkg.sv
hdl/tds_front.sv
hdl/tds_back.sv
hdl/timer_deadline_scheduler.sv
test/timer_deadline_scheduler_chk.sv
test/timer_deadline_scheduler_tb.sv
